[hdl/tag_attribute_id_extractor_unit_assert.svh]
// Assertion macros used by the extractor core RTL.
`ifndef TAG_ATTRIBUTE_ID_EXTRACTOR_UNIT_ASSERT_SVH
`define TAG_ATTRIBUTE_ID_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TAIE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("taie assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TAIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("taie assertion failed");

`endif

[hdl/taie_pkg.sv]
`default_nettype none

package taie_pkg;

  typedef enum logic [2:0] {
    MODE_OUTSIDE    = 3'd0,
    MODE_NAME       = 3'd1,
    MODE_SEEK_MIME  = 3'd2,
    MODE_MIME_VALUE = 3'd3,
    MODE_SEEK_POST  = 3'd4,
    MODE_POST_VALUE = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] id_byte;
    logic       id_done;
    logic       animated;
  } result_t;

  localparam logic [3:0] MIME_NAME_LEN = 4'd9;
  localparam logic [3:0] POST_NAME_LEN = 4'd12;
  localparam logic [3:0] GIF_VALUE_LEN = 4'd9;
  localparam logic [3:0] LEN_MAX       = 4'd15;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // "data-mime"
  function automatic logic [7:0] mime_name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h64;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h74;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h2D;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h69;
      4'd7:    c = 8'h6D;
      4'd8:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "data-post-id"
  function automatic logic [7:0] post_name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h64;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h74;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h2D;
      4'd5:    c = 8'h70;
      4'd6:    c = 8'h6F;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h74;
      4'd9:    c = 8'h2D;
      4'd10:   c = 8'h69;
      4'd11:   c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "image/gif"
  function automatic logic [7:0] gif_value_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h69;
      4'd1:    c = 8'h6D;
      4'd2:    c = 8'h61;
      4'd3:    c = 8'h67;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h2F;
      4'd6:    c = 8'h67;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h66;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/taie_in_if.sv]
`default_nettype none

interface taie_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] page_byte;
  logic       page_end;

  modport source (output valid, output page_byte, output page_end, input ready);
  modport sink   (input valid, input page_byte, input page_end, output ready);
endinterface

`default_nettype wire

[hdl/taie_out_if.sv]
`default_nettype none

interface taie_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] id_byte;
  logic       id_done;
  logic       animated;

  modport source (output valid, output id_byte, output id_done, output animated, input ready);
  modport sink   (input valid, input id_byte, input id_done, input animated, output ready);
endinterface

`default_nettype wire

[hdl/taie_core.sv]
`default_nettype none

`include "tag_attribute_id_extractor_unit_assert.svh"

module taie_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             req_accept,
  input  wire logic [7:0]       req_byte,
  input  wire logic             req_last,
  output taie_pkg::result_t     res,
  output logic                  res_valid
);

  taie_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]      name_len_r, name_len_nxt;
  logic            mime_match_r, mime_match_nxt;
  logic            post_match_r, post_match_nxt;
  logic [3:0]      value_len_r, value_len_nxt;
  logic            gif_match_r, gif_match_nxt;
  logic            anim_r, anim_nxt;

  always_comb begin
    mode_nxt       = mode_r;
    name_len_nxt   = name_len_r;
    mime_match_nxt = mime_match_r;
    post_match_nxt = post_match_r;
    value_len_nxt  = value_len_r;
    gif_match_nxt  = gif_match_r;
    anim_nxt       = anim_r;

    unique case (mode_r)
      taie_pkg::MODE_OUTSIDE: begin
        if (req_byte == taie_pkg::CH_LT) begin
          name_len_nxt   = 4'd0;
          mime_match_nxt = 1'b1;
          post_match_nxt = 1'b1;
          mode_nxt       = taie_pkg::MODE_NAME;
        end
      end
      taie_pkg::MODE_NAME: begin
        if (req_byte == taie_pkg::CH_SPACE) begin
          name_len_nxt   = 4'd0;
          mime_match_nxt = 1'b1;
          post_match_nxt = 1'b1;
        end else if (req_byte == taie_pkg::CH_EQ && mime_match_r &&
                     name_len_r == taie_pkg::MIME_NAME_LEN) begin
          mode_nxt = taie_pkg::MODE_SEEK_MIME;
        end else if (req_byte == taie_pkg::CH_EQ && post_match_r &&
                     name_len_r == taie_pkg::POST_NAME_LEN) begin
          mode_nxt = taie_pkg::MODE_SEEK_POST;
        end else begin
          mime_match_nxt = mime_match_r && (name_len_r < taie_pkg::MIME_NAME_LEN) &&
                           (req_byte == taie_pkg::mime_name_char(name_len_r));
          post_match_nxt = post_match_r && (name_len_r < taie_pkg::POST_NAME_LEN) &&
                           (req_byte == taie_pkg::post_name_char(name_len_r));
          if (name_len_r != taie_pkg::LEN_MAX) begin
            name_len_nxt = name_len_r + 4'd1;
          end
          if (req_byte == taie_pkg::CH_GT) begin
            mode_nxt = taie_pkg::MODE_OUTSIDE;
          end
        end
      end
      taie_pkg::MODE_SEEK_MIME: begin
        if (req_byte == taie_pkg::CH_QUOTE) begin
          value_len_nxt = 4'd0;
          gif_match_nxt = 1'b1;
          mode_nxt      = taie_pkg::MODE_MIME_VALUE;
        end
      end
      taie_pkg::MODE_MIME_VALUE: begin
        if (req_byte == taie_pkg::CH_QUOTE) begin
          anim_nxt       = gif_match_r && (value_len_r == taie_pkg::GIF_VALUE_LEN);
          name_len_nxt   = 4'd0;
          mime_match_nxt = 1'b0;
          post_match_nxt = 1'b0;
          mode_nxt       = taie_pkg::MODE_NAME;
        end else begin
          gif_match_nxt = gif_match_r && (value_len_r < taie_pkg::GIF_VALUE_LEN) &&
                          (req_byte == taie_pkg::gif_value_char(value_len_r));
          if (value_len_r != taie_pkg::LEN_MAX) begin
            value_len_nxt = value_len_r + 4'd1;
          end
        end
      end
      taie_pkg::MODE_SEEK_POST: begin
        if (req_byte == taie_pkg::CH_QUOTE) begin
          mode_nxt = taie_pkg::MODE_POST_VALUE;
        end
      end
      taie_pkg::MODE_POST_VALUE: begin
        if (req_byte == taie_pkg::CH_QUOTE) begin
          name_len_nxt   = 4'd0;
          mime_match_nxt = 1'b1;
          post_match_nxt = 1'b1;
          mode_nxt       = taie_pkg::MODE_OUTSIDE;
        end
      end
      default: begin
        mode_nxt = taie_pkg::MODE_OUTSIDE;
      end
    endcase

    // page end: state returns to reset after the byte's result
    if (req_last) begin
      mode_nxt       = taie_pkg::MODE_OUTSIDE;
      name_len_nxt   = 4'd0;
      mime_match_nxt = 1'b1;
      post_match_nxt = 1'b1;
      value_len_nxt  = 4'd0;
      gif_match_nxt  = 1'b1;
      anim_nxt       = 1'b0;
    end
  end

  always_comb begin
    res_valid    = (mode_r == taie_pkg::MODE_POST_VALUE);
    res.id_byte  = req_byte;
    res.id_done  = 1'b0;
    res.animated = anim_r;
    if (mode_r == taie_pkg::MODE_POST_VALUE && req_byte == taie_pkg::CH_QUOTE) begin
      res.id_byte = 8'h00;
      res.id_done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= taie_pkg::MODE_OUTSIDE;
      name_len_r   <= 4'd0;
      mime_match_r <= 1'b1;
      post_match_r <= 1'b1;
      value_len_r  <= 4'd0;
      gif_match_r  <= 1'b1;
      anim_r       <= 1'b0;
    end else if (req_accept) begin
      mode_r       <= mode_nxt;
      name_len_r   <= name_len_nxt;
      mime_match_r <= mime_match_nxt;
      post_match_r <= post_match_nxt;
      value_len_r  <= value_len_nxt;
      gif_match_r  <= gif_match_nxt;
      anim_r       <= anim_nxt;
    end
  end

  `TAIE_ASSERT_NEXT(a_last_resets, req_accept && req_last,
    mode_r == taie_pkg::MODE_OUTSIDE && name_len_r == 4'd0 && !anim_r)
  `TAIE_ASSERT_NOW(a_result_only_in_value, res_valid,
    mode_r == taie_pkg::MODE_POST_VALUE)
  `TAIE_ASSERT_NEXT(a_close_quote_exits,
    req_accept && mode_r == taie_pkg::MODE_POST_VALUE && req_byte == taie_pkg::CH_QUOTE,
    mode_r == taie_pkg::MODE_OUTSIDE)
  `TAIE_ASSERT_NEXT(a_flag_held,
    !(req_accept && (req_last || mode_r == taie_pkg::MODE_MIME_VALUE)),
    $stable(anim_r))

endmodule

`default_nettype wire

[hdl/tag_attribute_id_extractor_unit.sv]
// Pulls post identifiers out of page markup, one byte per request on in_chan. A new
// byte can be taken in every cycle while in_chan.ready is high; its result, if any,
// appears in the out_chan register the cycle after. in_chan.ready is high whenever
// that result register is empty or is being drained in the same cycle, so the only
// stall comes from out_chan.ready. Each byte of a post-id attribute value yields
// one request with id_done low; the closing quote yields one with id_done high and
// id_byte zero. A request with page_end high returns all parser state, including
// the animated flag, to its reset values.
`default_nettype none

module tag_attribute_id_extractor_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  taie_in_if.sink    in_chan,
  taie_out_if.source out_chan
);

  logic              in_accept;
  logic              core_valid;
  taie_pkg::result_t core_res;
  logic              out_valid_r;
  taie_pkg::result_t out_res_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  taie_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_accept (in_accept),
    .req_byte   (in_chan.page_byte),
    .req_last   (in_chan.page_end),
    .res        (core_res),
    .res_valid  (core_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= core_valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && core_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.id_byte  = out_res_r.id_byte;
  assign out_chan.id_done  = out_res_r.id_done;
  assign out_chan.animated = out_res_r.animated;

endmodule

`default_nettype wire

[bench/tb_tag_attribute_id_extractor_unit.sv]
`timescale 1ns / 1ps

module tb_tag_attribute_id_extractor_unit;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_TARGET = 1050;

  localparam logic [95:0] MIME_ATTR = 96'("data-mime");
  localparam logic [95:0] POST_ATTR = 96'("data-post-id");
  localparam logic [95:0] GIF_TEXT  = 96'("image/gif");

  typedef struct packed {
    logic [7:0] b;
    logic       pend;
  } page_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  taie_in_if  in_if ();
  taie_out_if out_if ();

  tag_attribute_id_extractor_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #4 clk = ~clk;

  // parser image
  taie_pkg::mode_t pmode;
  logic [3:0] name_len;
  logic [3:0] val_len;
  logic       mime_ok;
  logic       post_ok;
  logic       gif_ok;
  logic       anim;

  page_item_t        page_q[$];
  taie_pkg::result_t id_q[$];
  taie_pkg::result_t want;
  page_item_t        cur;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  logic in_v;
  int   in_wait = 0;
  int   out_wait = 0;
  int   in_calm = 0;
  int   out_calm = 0;
  int   end_odds = 0;
  int   n_queued = 0;
  int   n_bytes = 0;
  int   n_pages = 0;
  int   n_id_bytes = 0;
  int   n_ids = 0;
  int   errors = 0;
  int   cycles = 0;

  function automatic logic [7:0] attr_char(input logic [95:0] s, input logic [3:0] len,
                                           input logic [3:0] idx);
    int n;
    int i;
    n = int'(len);
    i = int'(idx);
    if (i >= n) return 8'h00;
    return s[8*(n-1-i) +: 8];
  endfunction

  task automatic clear_attr_name();
    name_len = 4'd0;
    mime_ok  = 1'b1;
    post_ok  = 1'b1;
  endtask

  task automatic reset_parser();
    pmode   = taie_pkg::MODE_OUTSIDE;
    clear_attr_name();
    val_len = 4'd0;
    gif_ok  = 1'b1;
    anim    = 1'b0;
  endtask

  task automatic parse_page_byte(input logic [7:0] b, input logic pend);
    taie_pkg::result_t r;
    case (pmode)
      taie_pkg::MODE_OUTSIDE: begin
        if (b == taie_pkg::CH_LT) begin
          clear_attr_name();
          pmode = taie_pkg::MODE_NAME;
        end
      end
      taie_pkg::MODE_NAME: begin
        if (b == taie_pkg::CH_SPACE) begin
          clear_attr_name();
        end else if (b == taie_pkg::CH_EQ && mime_ok &&
                     name_len == taie_pkg::MIME_NAME_LEN) begin
          pmode = taie_pkg::MODE_SEEK_MIME;
        end else if (b == taie_pkg::CH_EQ && post_ok &&
                     name_len == taie_pkg::POST_NAME_LEN) begin
          pmode = taie_pkg::MODE_SEEK_POST;
        end else begin
          mime_ok = mime_ok && name_len < taie_pkg::MIME_NAME_LEN &&
                    b == attr_char(MIME_ATTR, taie_pkg::MIME_NAME_LEN, name_len);
          post_ok = post_ok && name_len < taie_pkg::POST_NAME_LEN &&
                    b == attr_char(POST_ATTR, taie_pkg::POST_NAME_LEN, name_len);
          if (name_len != taie_pkg::LEN_MAX) name_len = name_len + 4'd1;
          if (b == taie_pkg::CH_GT) pmode = taie_pkg::MODE_OUTSIDE;
        end
      end
      taie_pkg::MODE_SEEK_MIME: begin
        if (b == taie_pkg::CH_QUOTE) begin
          val_len = 4'd0;
          gif_ok  = 1'b1;
          pmode   = taie_pkg::MODE_MIME_VALUE;
        end
      end
      taie_pkg::MODE_MIME_VALUE: begin
        if (b == taie_pkg::CH_QUOTE) begin
          anim     = gif_ok && val_len == taie_pkg::GIF_VALUE_LEN;
          name_len = 4'd0;
          mime_ok  = 1'b0;
          post_ok  = 1'b0;
          pmode    = taie_pkg::MODE_NAME;
        end else begin
          gif_ok = gif_ok && val_len < taie_pkg::GIF_VALUE_LEN &&
                   b == attr_char(GIF_TEXT, taie_pkg::GIF_VALUE_LEN, val_len);
          if (val_len != taie_pkg::LEN_MAX) val_len = val_len + 4'd1;
        end
      end
      taie_pkg::MODE_SEEK_POST: begin
        if (b == taie_pkg::CH_QUOTE) pmode = taie_pkg::MODE_POST_VALUE;
      end
      taie_pkg::MODE_POST_VALUE: begin
        r.animated = anim;
        if (b == taie_pkg::CH_QUOTE) begin
          r.id_byte = 8'h00;
          r.id_done = 1'b1;
          clear_attr_name();
          pmode = taie_pkg::MODE_OUTSIDE;
        end else begin
          r.id_byte = b;
          r.id_done = 1'b0;
        end
        id_q = {id_q, r};
      end
      default: pmode = taie_pkg::MODE_OUTSIDE;
    endcase
    if (pend) reset_parser();
  endtask

  task automatic draw_wait(inout int calm, output int w);
    if (calm > 0) begin
      calm--;
      w = 0;
    end else begin
      if ($urandom_range(0, 31) == 0) calm = $urandom_range(8, 40);
      w = $urandom_range(0, 11);
    end
  endtask

  task automatic push_item(input logic [7:0] b, input logic pend);
    page_item_t it;
    it.b    = b;
    it.pend = pend;
    page_q = {page_q, it};
    n_queued++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(b, end_odds != 0 && $urandom_range(1, end_odds) == 1);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // non-quote byte, leaning on the markup characters
  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0:       b = taie_pkg::CH_GT;
      1:       b = taie_pkg::CH_LT;
      2:       b = taie_pkg::CH_EQ;
      3:       b = taie_pkg::CH_SPACE;
      default: b = 8'($urandom());
    endcase
    if (b == taie_pkg::CH_QUOTE) b = 8'h30;
    return b;
  endfunction

  task automatic push_value(input int n);
    for (int i = 0; i < n; i++) push_byte(value_byte());
  endtask

  task automatic gen_tag();
    int kind;
    int n;
    kind = $urandom_range(0, 11);
    case (kind)
      0: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) push_byte(8'($urandom()));
      end
      1, 2, 3, 4: begin
        push_text("<");
        if ($urandom_range(0, 1) == 1) push_text("a='b=c' ");
        push_text("data-post-id=");
        push_value($urandom_range(0, 3));
        push_byte(taie_pkg::CH_QUOTE);
        push_value($urandom_range(0, 8));
        push_byte(taie_pkg::CH_QUOTE);
      end
      5, 6: begin
        push_text("<data-mime=");
        push_value($urandom_range(0, 2));
        push_byte(taie_pkg::CH_QUOTE);
        case ($urandom_range(0, 6))
          0, 1:    push_text("image/gif");
          2:       push_text("image/gi");
          3:       push_text("image/gifs");
          4:       push_text("image/png");
          5:       push_text("image/gifimage/gif");
          default: ;
        endcase
        push_byte(taie_pkg::CH_QUOTE);
        case ($urandom_range(0, 2))
          0: begin
            push_text(" data-post-id='");
            push_value($urandom_range(0, 5));
            push_byte(taie_pkg::CH_QUOTE);
          end
          1:       push_text("data-post-id='7'>");
          default: push_text(">");
        endcase
      end
      7: begin
        case ($urandom_range(0, 3))
          0:       push_text("<data-post-i='1'>");
          1:       push_text("<data-post-idd='1'>");
          2:       push_text("<data-mim='image/gif'>");
          default: push_text("<data-mimee='x'>");
        endcase
      end
      8: begin
        push_text("<");
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) push_text("z");
        push_text("data-post-id='5'>");
      end
      9: begin
        if ($urandom_range(0, 1) == 1) push_text("<q=data-post-id='3'>");
        else push_text("<q= data-post-id='3'");
      end
      10: begin
        if ($urandom_range(0, 1) == 1) push_text("<abc><data-post-id='9'");
        else push_text("<ab<data-post-id='9'>");
      end
      default: begin
        push_text("<data-post-id>");
        push_value($urandom_range(0, 4));
      end
    endcase
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      in_v = in_if.valid && !in_took;
      if (!in_v) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (page_q.size() != 0) begin
          cur = page_q.pop_front();
          in_if.page_byte <= cur.b;
          in_if.page_end  <= cur.pend;
          in_v = 1'b1;
          draw_wait(in_calm, in_wait);
        end
      end
      in_if.valid <= in_v;

      if (out_took) draw_wait(out_calm, out_wait);
      if (out_wait > 0) begin
        out_if.ready <= 1'b0;
        out_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_if.valid && in_if.ready;
      out_took <= out_if.valid && out_if.ready;
      if (in_if.valid && in_if.ready) begin
        n_bytes++;
        if (in_if.page_end) n_pages++;
        parse_page_byte(in_if.page_byte, in_if.page_end);
      end
      if (out_if.valid && out_if.ready) begin
        if (id_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: id_byte=%h id_done=%b animated=%b",
                     out_if.id_byte, out_if.id_done, out_if.animated);
        end else begin
          want = id_q.pop_front();
          if (out_if.id_byte !== want.id_byte || out_if.id_done !== want.id_done ||
              out_if.animated !== want.animated) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: id_byte=%h/%h id_done=%b/%b animated=%b/%b (exp/act)",
                       want.id_byte, out_if.id_byte, want.id_done, out_if.id_done,
                       want.animated, out_if.animated);
          end
          if (want.id_done) n_ids++;
          else n_id_bytes++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_tag_attribute_id_extractor_unit: done, errors");
      $finish;
    end
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.page_byte = 8'h00;
    in_if.page_end  = 1'b0;
    out_if.ready    = 1'b0;
    reset_parser();

    // directed: byte extremes outside, extreme id bytes, page end mid tag and outside
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_text("<data-post-id='");
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(taie_pkg::CH_QUOTE, 1'b0);
    push_item(taie_pkg::CH_LT, 1'b1);
    push_item(8'hFF, 1'b1);

    end_odds = 150;
    while (n_queued < ITEM_TARGET) begin
      gen_tag();
      if ($urandom_range(0, 7) == 0) push_item(8'($urandom()), 1'b1);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (page_q.size() != 0 || in_if.valid || id_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (id_q.size() != 0) begin
      $display("%0d expected results never arrived", id_q.size());
      errors += id_q.size();
    end
    $display("sent %0d page bytes across %0d page ends", n_bytes, n_pages);
    $display("checked %0d id bytes and %0d id terminators, %0d errors",
             n_id_bytes, n_ids, errors);
    if (errors == 0) begin
      $display("tb_tag_attribute_id_extractor_unit: done, clean");
    end else begin
      $display("tb_tag_attribute_id_extractor_unit: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/taie_pkg.sv
hdl/taie_in_if.sv
hdl/taie_out_if.sv
hdl/taie_core.sv
hdl/tag_attribute_id_extractor_unit.sv
bench/tb_tag_attribute_id_extractor_unit.sv
